// File: design/salc_pkg.sv
// shared types, codes and helpers for the set-associative lru cache model
package salc_pkg;

  // access kinds
  localparam logic [1:0] KIND_IFETCH = 2'd0;
  localparam logic [1:0] KIND_LOAD   = 2'd1;
  localparam logic [1:0] KIND_STORE  = 2'd2;
  localparam logic [1:0] KIND_MODIFY = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [1:0] CFG_WAYS_IN_USE = 2'd1;
  localparam logic [1:0] CFG_BLOCK_BITS  = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  typedef struct packed {
    logic [1:0]  access_kind;
    logic [31:0] address;
  } salc_in_t;

  typedef struct packed {
    logic [1:0]  hits_added;
    logic        missed;
    logic        evicted;
    logic [31:0] total_hits;
    logic [31:0] total_misses;
    logic [31:0] total_evictions;
  } salc_out_t;

  typedef struct packed {
    logic [2:0] set_bits;
    logic [2:0] ways_in_use;
    logic [3:0] block_bits;
  } salc_cfg_t;

  // classified access handed from front to back
  typedef struct packed {
    logic        access;
    logic        modify;
    logic [31:0] tag;
  } salc_op_t;

  // one cache line as stored in a way memory
  typedef struct packed {
    logic        valid;
    logic [31:0] tag;
    logic [31:0] stamp;
  } salc_line_t;

  function automatic logic [31:0] sat_add(logic [31:0] v, logic [1:0] n);
    logic [32:0] s;
    s = {1'b0, v} + 33'(n);
    return s[32] ? '1 : s[31:0];
  endfunction

endpackage

// File: design/salc_ram.sv
// generic single-write, single-read ram with registered read data
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/salc_fifo.sv
// short first-in first-out queue between front and back
module salc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/salc_front.sv
// front end: accepts accesses, splits the address into tag and set
module salc_front import salc_pkg::*; #(
  parameter int MAX_SETS = 32
) (
  input  salc_cfg_t                                       cfg,
  input  logic                                            clear_done,
  input  logic                                            in_valid,
  input  salc_in_t                                        in_data,
  output logic                                            in_ready,
  input  logic                                            q_ready,
  output logic                                            q_push,
  output salc_op_t                                        q_op,
  output logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] q_set
);

  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  // largest set-bit count whose set count fits
  localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int SB_W   = $clog2(SB_MAX + 2);

  logic [SB_W-1:0]  eff_sb;
  logic [5:0]       tag_sh;
  logic [SET_W:0]   one_sh;
  logic [SET_W-1:0] set_mask;
  logic [31:0]      addr_sh;

  always_comb begin
    if (32'(cfg.set_bits) > SB_MAX) begin
      eff_sb = SB_W'(SB_MAX);
    end else begin
      eff_sb = SB_W'(cfg.set_bits);
    end
    tag_sh   = 6'(cfg.block_bits) + 6'(eff_sb);
    one_sh   = (SET_W+1)'(1) << eff_sb;
    set_mask = SET_W'(one_sh - (SET_W+1)'(1));
    addr_sh  = in_data.address >> cfg.block_bits;
  end

  assign in_ready  = q_ready && clear_done;
  assign q_push    = in_valid && in_ready;
  assign q_set     = SET_W'(addr_sh) & set_mask;
  assign q_op.tag  = in_data.address >> tag_sh;
  assign q_op.access = (in_data.access_kind != KIND_IFETCH);
  assign q_op.modify = (in_data.access_kind == KIND_MODIFY);

endmodule

// File: design/salc_back.sv
// back end: way lookup, lru victim choice, line writeback and running totals
module salc_back import salc_pkg::*; #(
  parameter int MAX_SETS = 32,
  parameter int MAX_WAYS = 4
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  salc_cfg_t                                       cfg,
  output logic                                            clear_done,
  input  logic                                            q_valid,
  input  salc_op_t                                        q_op,
  input  logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] q_set,
  output logic                                            q_pop,
  output logic                                            out_valid,
  output salc_out_t                                       out_data,
  input  logic                                            out_ready
);

  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W = $clog2(MAX_WAYS + 1);
  localparam int LINE_W = $bits(salc_line_t);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [SET_W-1:0] clr_idx_r, clr_idx_nxt;
  salc_op_t         cur_op_r;
  logic [SET_W-1:0] cur_set_r;
  logic [31:0]      clock_r;
  logic [31:0]      hit_total_r, miss_total_r, evict_total_r;
  logic [31:0]      hit_total_nxt, miss_total_nxt, evict_total_nxt;
  logic             out_valid_r;
  salc_out_t        out_data_r, res_nxt;

  logic                out_free, rd_en, commit, emit_fetch;
  logic [MAX_WAYS-1:0] way_we;
  logic [SET_W-1:0]    wr_addr;
  salc_line_t          wr_word;
  salc_line_t          rd_line [MAX_WAYS];

  logic [WCNT_W-1:0]   eff_ways;
  logic [MAX_WAYS-1:0] in_use, match, free;
  logic [31:0]         age [MAX_WAYS];
  logic [31:0]         best_age;
  logic [WAY_W-1:0]    hit_way, free_way, lru_way, fill_way;
  logic                hit, has_free, evict;
  logic [1:0]          hits_n;

  for (genvar g = 0; g < MAX_WAYS; g++) begin : g_way
    salc_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_SETS)
    ) u_ram (
      .clk     (clk),
      .wr_en   (way_we[g]),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (rd_en),
      .rd_addr (q_set),
      .rd_data (rd_line[g])
    );
  end

  assign out_free   = !out_valid_r || out_ready;
  assign clear_done = (state_r != ST_CLEAR);

  // associativity clamp
  always_comb begin
    if (cfg.ways_in_use == '0) begin
      eff_ways = WCNT_W'(1);
    end else if (32'(cfg.ways_in_use) > MAX_WAYS) begin
      eff_ways = WCNT_W'(MAX_WAYS);
    end else begin
      eff_ways = WCNT_W'(cfg.ways_in_use);
    end
  end

  // tag compare, free-way search and oldest-stamp search over the set
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    lru_way  = '0;
    best_age = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = (eff_ways > WCNT_W'(w));
      match[w]  = in_use[w] && rd_line[w].valid && (rd_line[w].tag == cur_op_r.tag);
      free[w]   = in_use[w] && !rd_line[w].valid;
      age[w]    = clock_r - rd_line[w].stamp;
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_way = WAY_W'(w);
      if (free[w]) free_way = WAY_W'(w);
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (in_use[w] && (w == 0 || age[w] > best_age)) begin
        best_age = age[w];
        lru_way  = WAY_W'(w);
      end
    end
    hit      = |match;
    has_free = |free;
    evict    = !hit && !has_free;
    fill_way = hit ? hit_way : (has_free ? free_way : lru_way);
    // the second access of a modify always hits the line just touched
    hits_n   = 2'(hit) + 2'(cur_op_r.modify);
    hit_total_nxt   = sat_add(hit_total_r, hits_n);
    miss_total_nxt  = sat_add(miss_total_r, {1'b0, !hit});
    evict_total_nxt = sat_add(evict_total_r, {1'b0, evict});
  end

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    q_pop       = 1'b0;
    rd_en       = 1'b0;
    way_we      = '0;
    wr_addr     = cur_set_r;
    wr_word     = '0;
    commit      = 1'b0;
    emit_fetch  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        way_we  = '1;
        wr_addr = clr_idx_r;
        if (clr_idx_r == SET_W'(MAX_SETS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + SET_W'(1);
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          if (!q_op.access) begin
            if (out_free) begin
              q_pop      = 1'b1;
              emit_fetch = 1'b1;
            end
          end else begin
            q_pop     = 1'b1;
            rd_en     = 1'b1;
            state_nxt = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        if (out_free) begin
          commit           = 1'b1;
          way_we[fill_way] = 1'b1;
          wr_word.valid    = 1'b1;
          wr_word.tag      = cur_op_r.tag;
          wr_word.stamp    = clock_r;
          state_nxt        = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    if (commit) begin
      res_nxt.hits_added      = hits_n;
      res_nxt.missed          = !hit;
      res_nxt.evicted         = evict;
      res_nxt.total_hits      = hit_total_nxt;
      res_nxt.total_misses    = miss_total_nxt;
      res_nxt.total_evictions = evict_total_nxt;
    end else begin
      res_nxt.hits_added      = '0;
      res_nxt.missed          = 1'b0;
      res_nxt.evicted         = 1'b0;
      res_nxt.total_hits      = hit_total_r;
      res_nxt.total_misses    = miss_total_r;
      res_nxt.total_evictions = evict_total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_idx_r     <= '0;
      out_valid_r   <= 1'b0;
      clock_r       <= '0;
      hit_total_r   <= '0;
      miss_total_r  <= '0;
      evict_total_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      if (commit) begin
        clock_r       <= clock_r + 32'd1;
        hit_total_r   <= hit_total_nxt;
        miss_total_r  <= miss_total_nxt;
        evict_total_r <= evict_total_nxt;
      end
      if (commit || emit_fetch) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_op_r  <= q_op;
      cur_set_r <= q_set;
    end
    if (commit || emit_fetch) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !out_valid_r)
    else $error("result presented during clearing pass");

  a_one_way_written: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOOK |-> $onehot0(way_we))
    else $error("lookup wrote more than one way");

  a_clock_steps: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> clock_r == $past(clock_r) + 32'd1)
    else $error("access clock did not advance on commit");

  a_hits_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> hit_total_r >= $past(hit_total_r))
    else $error("hit total went backwards");

endmodule

// File: design/set_assoc_lru_cache_model.sv
// top level of the set-associative lru cache model: config registers, front, queue, back
// a load, store or modify passes the queue, the way-memory read and the output register,
//   an instruction fetch the queue and the output register; a stalled output adds its wait
// a load/store/modify set is read from the way memories, then tag/stamp is written back to
//   the same set before the next is taken; one instruction fetch per cycle while unstalled
// reset: synchronous active-low; afterwards a clearing pass over all MAX_SETS sets marks
//   every line invalid, in_ready stays low meanwhile, cfg_ writes are taken throughout
module set_assoc_lru_cache_model import salc_pkg::*; #(
  parameter int MAX_SETS = 32,
  parameter int MAX_WAYS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  salc_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output salc_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int Q_W     = $bits(salc_op_t) + SET_W;
  // two entries let the front take a transaction while the back finishes one
  localparam int Q_DEPTH = 2;

  salc_cfg_t cfg_r;

  // front to queue
  logic             f_push;
  salc_op_t         f_op;
  logic [SET_W-1:0] f_set;
  logic             q_ready;

  // queue to back
  logic             q_valid, q_pop;
  logic [Q_W-1:0]   q_word;
  salc_op_t         b_op;
  logic [SET_W-1:0] b_set;
  logic             clear_done;

  // configuration registers, always writable; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.set_bits    <= 3'd0;
      cfg_r.ways_in_use <= 3'd1;
      cfg_r.block_bits  <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SET_BITS:    cfg_r.set_bits    <= cfg_data[2:0];
        CFG_WAYS_IN_USE: cfg_r.ways_in_use <= cfg_data[2:0];
        CFG_BLOCK_BITS:  cfg_r.block_bits  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // address split and access classification
  salc_front #(
    .MAX_SETS (MAX_SETS)
  ) u_front (
    .cfg        (cfg_r),
    .clear_done (clear_done),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_ready   (in_ready),
    .q_ready    (q_ready),
    .q_push     (f_push),
    .q_op       (f_op),
    .q_set      (f_set)
  );

  // decoupling queue, keeps transaction order
  salc_fifo #(
    .WIDTH (Q_W),
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_push),
    .push_data  ({f_op, f_set}),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_word)
  );

  assign b_op  = q_word[Q_W-1:SET_W];
  assign b_set = q_word[SET_W-1:0];

  // lookup, replacement, writeback, totals and output register
  salc_back #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .clear_done (clear_done),
    .q_valid    (q_valid),
    .q_op       (b_op),
    .q_set      (b_set),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_ready  (out_ready)
  );

endmodule

// File: verif/cache_check_pkg.sv
// scoreboard for the lru cache model: own cache state, expected outcomes and the check
package cache_check_pkg;
  import salc_pkg::*;

  localparam int SETS_MAX  = 32;
  localparam int WAYS_MAX  = 4;
  localparam int LINES_MAX = SETS_MAX * WAYS_MAX;

  class lru_cache_scoreboard;
    bit          line_ok[LINES_MAX];
    logic [31:0] line_tag[LINES_MAX];
    logic [31:0] line_stamp[LINES_MAX];
    logic [31:0] tick;
    logic [31:0] hit_sum;
    logic [31:0] miss_sum;
    logic [31:0] evict_sum;
    logic [2:0]  set_bits_reg;
    logic [2:0]  ways_reg;
    logic [3:0]  block_bits_reg;
    salc_out_t   expected_outcomes[$];
    int unsigned fail_count;

    function new();
      foreach (line_ok[i]) begin
        line_ok[i]    = 1'b0;
        line_tag[i]   = '0;
        line_stamp[i] = '0;
      end
      tick           = '0;
      hit_sum        = '0;
      miss_sum       = '0;
      evict_sum      = '0;
      set_bits_reg   = 3'd0;
      ways_reg       = 3'd1;
      block_bits_reg = 4'd0;
      fail_count     = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SET_BITS:    set_bits_reg   = data[2:0];
        CFG_WAYS_IN_USE: ways_reg       = data[2:0];
        CFG_BLOCK_BITS:  block_bits_reg = data[3:0];
        default: ;
      endcase
    endfunction

    // set index width, clipped so the set count fits
    function int unsigned set_field_bits();
      int unsigned s;
      s = 0;
      while (s < 32'(set_bits_reg) && (1 << (s + 1)) <= SETS_MAX) s++;
      return s;
    endfunction

    function int unsigned active_ways();
      if (ways_reg == 3'd0) return 1;
      if (32'(ways_reg) > WAYS_MAX) return WAYS_MAX;
      return 32'(ways_reg);
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
    endfunction

    // one lookup in a set; returns 1 on hit, fills a free or the oldest way on miss
    function bit probe_line(logic [31:0] tag, int unsigned set, inout bit replaced);
      int unsigned ways;
      int unsigned base;
      int unsigned victim;
      logic [31:0] age;
      logic [31:0] oldest;
      bit          have_free;
      ways      = active_ways();
      base      = set * WAYS_MAX;
      victim    = 0;
      have_free = 1'b0;
      oldest    = '0;
      for (int w = 0; w < ways; w++) begin
        if (line_ok[base + w] && line_tag[base + w] == tag) begin
          line_stamp[base + w] = tick;
          hit_sum = bump(hit_sum);
          return 1'b1;
        end
      end
      for (int w = 0; w < ways; w++) begin
        if (!line_ok[base + w]) begin
          victim    = w;
          have_free = 1'b1;
          break;
        end
      end
      if (!have_free) begin
        // age wraps with the clock, ties keep the lowest way
        for (int w = 0; w < ways; w++) begin
          age = tick - line_stamp[base + w];
          if (w == 0 || age > oldest) begin
            oldest = age;
            victim = w;
          end
        end
        evict_sum = bump(evict_sum);
        replaced  = 1'b1;
      end
      miss_sum = bump(miss_sum);
      line_ok[base + victim]    = 1'b1;
      line_tag[base + victim]   = tag;
      line_stamp[base + victim] = tick;
      return 1'b0;
    endfunction

    function void note_access(salc_in_t acc);
      salc_out_t   want;
      int unsigned sbits;
      int unsigned set;
      logic [31:0] tag;
      logic [1:0]  hits;
      bit          replaced;
      bit          first_miss;
      want       = '0;
      hits       = 2'd0;
      replaced   = 1'b0;
      first_miss = 1'b0;
      if (acc.access_kind != KIND_IFETCH) begin
        sbits = set_field_bits();
        set   = (acc.address >> block_bits_reg) & ((1 << sbits) - 1);
        tag   = acc.address >> (32'(block_bits_reg) + sbits);
        if (probe_line(tag, set, replaced)) hits++;
        else first_miss = 1'b1;
        if (acc.access_kind == KIND_MODIFY && probe_line(tag, set, replaced)) hits++;
        tick = tick + 32'd1;
      end
      want.hits_added      = hits;
      want.missed          = first_miss;
      want.evicted         = replaced;
      want.total_hits      = hit_sum;
      want.total_misses    = miss_sum;
      want.total_evictions = evict_sum;
      expected_outcomes.push_back(want);
    endfunction

    function void flag(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
    endfunction

    function void check_outcome(salc_out_t got);
      salc_out_t want;
      if (expected_outcomes.size() == 0) begin
        flag("result transaction with nothing outstanding");
        return;
      end
      want = expected_outcomes.pop_front();
      if (got.hits_added !== want.hits_added || got.missed !== want.missed ||
          got.evicted !== want.evicted || got.total_hits !== want.total_hits ||
          got.total_misses !== want.total_misses ||
          got.total_evictions !== want.total_evictions)
        flag($sformatf({"mismatch exp/got: hits %0d/%0d miss %0b/%0b evict %0b/%0b",
                        " tot_hit %0d/%0d tot_miss %0d/%0d tot_evict %0d/%0d"},
                       want.hits_added, got.hits_added, want.missed, got.missed,
                       want.evicted, got.evicted, want.total_hits, got.total_hits,
                       want.total_misses, got.total_misses,
                       want.total_evictions, got.total_evictions));
    endfunction

    function int unsigned pending();
      return expected_outcomes.size();
    endfunction

    function void close_out();
      if (expected_outcomes.size() != 0)
        flag($sformatf("%0d results never arrived", expected_outcomes.size()));
    endfunction
  endclass

endpackage

// File: verif/testbench.sv
// top level testbench for the set-associative lru cache model
module testbench import salc_pkg::*, cache_check_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // index with no register behind it, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 200;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  salc_in_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  salc_out_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lru_cache_scoreboard sb;
  logic [31:0]         tag_pool[6];
  bit                  calm;     // no idling on either side once set
  bit                  hold_go;  // asks the result sink for its long hold-off

  set_assoc_lru_cache_model u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("set_assoc_lru_cache_model verification failed");
    $finish;
  end

  // result sink: checks every accepted transaction, stalls in short random bursts
  // and once holds off for a long stretch so the block backs up into its input
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_done;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_outcome(out_data);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        // starts a stall burst, this one included; stall_left counts the rest of it
        stall_left = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic salc_in_t mk(logic [1:0] kind, logic [31:0] addr);
    salc_in_t acc;
    acc.access_kind = kind;
    acc.address     = addr;
    return acc;
  endfunction

  // builds an address from tag, set and offset under the current field split
  function automatic logic [31:0] compose(logic [31:0] tag, int unsigned set, logic [31:0] off);
    int unsigned sbits;
    int unsigned bb;
    sbits = sb.set_field_bits();
    bb    = 32'(sb.block_bits_reg);
    return (tag << (bb + sbits)) | ((set & ((1 << sbits) - 1)) << bb) |
           (off & ((32'd1 << bb) - 32'd1));
  endfunction

  function automatic logic [1:0] pick_kind();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return KIND_IFETCH;
    if (r < 4)  return KIND_LOAD;
    if (r < 7)  return KIND_STORE;
    return KIND_MODIFY;
  endfunction

  // mostly a few tags over a few sets so hits, fills and evictions all show up
  function automatic logic [31:0] pick_address();
    if ($urandom_range(0, 99) < 15) return $urandom();
    return compose(tag_pool[$urandom_range(0, 5)], $urandom_range(0, 2), $urandom());
  endfunction

  // offers one transaction, now and then after a short gap, and waits for acceptance
  task automatic send_access(salc_in_t acc);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= acc;
    do @(posedge clk); while (!in_ready);
    sb.note_access(acc);
  endtask

  // leaves cfg_valid high so back-to-back writes need no extra edge
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.apply_reg(idx, data);
  endtask

  // drains the block, then rewrites all three registers and, if asked, the spare index
  task automatic setup_phase(logic [3:0] sets, logic [3:0] ways, logic [3:0] block,
                             bit poke_spare);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write(CFG_SET_BITS, sets);
    cfg_write(CFG_WAYS_IN_USE, ways);
    cfg_write(CFG_BLOCK_BITS, block);
    if (poke_spare) cfg_write(CFG_SPARE_INDEX, 4'($urandom_range(0, 15)));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(int unsigned n_counted);
    int unsigned done_cnt;
    salc_in_t    acc;
    foreach (tag_pool[i]) tag_pool[i] = $urandom();
    done_cnt = 0;
    while (done_cnt < n_counted) begin
      acc.access_kind = pick_kind();
      acc.address     = pick_address();
      send_access(acc);
      // fetches leave the cache alone, so they do not count
      if (acc.access_kind != KIND_IFETCH) done_cnt++;
    end
  endtask

  initial begin : stimulus
    sb      = new();
    calm    = 1'b0;
    hold_go = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: one set, one way, byte blocks
    send_access(mk(KIND_IFETCH, 32'h0000_0000));  // totals still zero
    send_access(mk(KIND_LOAD,   32'h0000_0000));  // cold miss
    send_access(mk(KIND_LOAD,   32'h0000_0000));  // hit
    send_access(mk(KIND_STORE,  32'hFFFF_FFFF));  // miss, evicts the only way
    send_access(mk(KIND_MODIFY, 32'hFFFF_FFFF));  // two hits
    send_access(mk(KIND_MODIFY, 32'h0000_0000));  // miss with eviction, then hit
    send_access(mk(KIND_IFETCH, 32'hFFFF_FFFF));  // totals repeated

    // out-of-range set bits and ways clip to 5 and 4, widest block offset
    setup_phase(4'd7, 4'd7, 4'd15, 1'b1);
    send_access(mk(KIND_LOAD,   compose(32'h1, 3, 32'h0)));
    send_access(mk(KIND_LOAD,   compose(32'h2, 3, 32'h1)));
    send_access(mk(KIND_STORE,  compose(32'h3, 3, 32'h2)));
    send_access(mk(KIND_LOAD,   compose(32'h4, 3, 32'h3)));  // set now full
    send_access(mk(KIND_LOAD,   compose(32'h1, 3, 32'h7FFF)));  // hit refreshes tag 1
    send_access(mk(KIND_LOAD,   compose(32'h5, 3, 32'h0)));  // evicts tag 2, not tag 1
    send_access(mk(KIND_STORE,  compose(32'h2, 3, 32'h0)));  // evicts tag 3
    send_access(mk(KIND_MODIFY, compose(32'h1, 3, 32'h10)));
    send_access(mk(KIND_MODIFY, compose(32'h800, 31, 32'h7FFF)));  // fill into empty set
    send_access(mk(KIND_IFETCH, 32'hFFFF_FFFF));
    send_access(mk(KIND_LOAD,   32'hFFFF_FFFF));  // free way left, no eviction

    // zero ways acts as one way
    setup_phase(4'd0, 4'd0, 4'd8, 1'b0);
    send_access(mk(KIND_LOAD,   32'h0000_0100));
    send_access(mk(KIND_LOAD,   32'h0000_01FF));  // same block, hit
    send_access(mk(KIND_STORE,  32'h0000_0200));  // evicts
    send_access(mk(KIND_MODIFY, 32'h0000_01FF));  // evicts, then hits

    setup_phase(4'd5, 4'd4, 4'd0, 1'b0);
    run_random_phase(60);

    // single set, four ways; the sink holds off during this phase
    setup_phase(4'd0, 4'd4, 4'd8, 1'b0);
    hold_go <= 1'b1;
    run_random_phase(60);

    setup_phase(4'd3, 4'd2, 4'd4, 1'b0);
    run_random_phase(60);

    setup_phase(4'($urandom_range(0, 7)), 4'($urandom_range(0, 7)),
                4'($urandom_range(0, 15)), 1'b1);
    run_random_phase(60);

    setup_phase(4'($urandom_range(0, 7)), 4'($urandom_range(0, 7)),
                4'($urandom_range(0, 15)), 1'b1);
    run_random_phase(60);

    // closing stretch runs at full rate on both sides
    calm = 1'b1;
    setup_phase(4'd1, 4'd3, 4'd15, 1'b0);
    run_random_phase(60);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    sb.close_out();
    if (sb.fail_count == 0)
      $display("set_assoc_lru_cache_model verification clean");
    else
      $display("set_assoc_lru_cache_model verification failed");
    $finish;
  end

endmodule

// File: files.f
design/salc_pkg.sv
design/salc_ram.sv
design/salc_fifo.sv
design/salc_front.sv
design/salc_back.sv
design/set_assoc_lru_cache_model.sv
verif/cache_check_pkg.sv
verif/testbench.sv
